// ===== rtl/core/gpm_pkg.sv =====
// Shared constants, codes and types of the glob pattern matcher.
package gpm_pkg;

   // Pattern store depth and the widths that follow from it.
   localparam int PATTERN_MAX = 32;
   localparam int IDX_W       = $clog2(PATTERN_MAX);
   localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
   localparam int POS_N       = PATTERN_MAX + 1;

   localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(PATTERN_MAX);
   localparam logic [POS_N-1:0] ACT_START = POS_N'(1);

   // Request queue between the front and back parts.
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Request operation codes.
   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_NAME   = 2'd2;

   // Pattern characters with a special meaning.
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_OPEN  = 8'h5B;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_CARET = 8'h5E;
   localparam logic [7:0] CH_CLOSE = 8'h5D;
   localparam logic [7:0] CH_DASH  = 8'h2D;

   // Back unit states.
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_PASS = 1'b1;

   // Bracket class parser states.
   localparam logic [2:0] CLS_NONE  = 3'd0;
   localparam logic [2:0] CLS_FIRST = 3'd1;
   localparam logic [2:0] CLS_ITEM  = 3'd2;
   localparam logic [2:0] CLS_DASH  = 3'd3;
   localparam logic [2:0] CLS_HI    = 3'd4;

   // One classified request as it travels through the queue.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
   } cmd_type;

endpackage

// ===== rtl/core/gpm_front.sv =====
// Front part: accepts requests, drops unused codes and queues the rest.
module gpm_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_op,
   input  logic [7:0]        req_data_byte,
   input  logic              req_is_last,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output gpm_pkg::cmd_type  cmd
);

   gpm_pkg::cmd_type                 ent_ff [gpm_pkg::Q_DEPTH];
   logic [gpm_pkg::Q_PTR_W-1:0]      wr_ff, wr_in, rd_ff, rd_in;
   logic [gpm_pkg::Q_CNT_W-1:0]      cnt_ff, cnt_in;
   logic                             known_op;
   logic                             push, pop;

   // Classify the request; the unused code is taken and dropped.
   always_comb begin
      case (req_op)
         gpm_pkg::OP_CLEAR:  known_op = 1'b1;
         gpm_pkg::OP_APPEND: known_op = 1'b1;
         gpm_pkg::OP_NAME:   known_op = 1'b1;
         default:            known_op = 1'b0;
      endcase
   end

   assign req_ready = (cnt_ff != gpm_pkg::Q_CNT_W'(gpm_pkg::Q_DEPTH));
   assign push      = req_valid & req_ready & known_op;
   assign cmd_valid = (cnt_ff != '0);
   assign pop       = cmd_valid & cmd_ready;
   assign cmd       = ent_ff[rd_ff];

   // Queue pointers and fill count.
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == gpm_pkg::Q_PTR_W'(gpm_pkg::Q_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == gpm_pkg::Q_PTR_W'(gpm_pkg::Q_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Queue entries.
   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ff] <= '{kind: req_op, data: req_data_byte, last: req_is_last};
      end
   end

endmodule

// ===== rtl/core/gpm_back.sv =====
// Back part: pattern store and the per-byte pass over the live positions.
module gpm_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  gpm_pkg::cmd_type  cmd,
   input  logic              filter_enabled,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_matched,
   output logic              rsp_pattern_overflow
);

   logic [7:0]                  pat_mem_ff [gpm_pkg::PATTERN_MAX];
   logic [7:0]                  rdata_ff;
   logic [gpm_pkg::IDX_W-1:0]   raddr;
   logic                        mem_we;

   logic                        state_ff, state_in;
   logic [gpm_pkg::LEN_W-1:0]   len_ff, len_in, pos_ff, pos_in, pos_p1;
   logic [gpm_pkg::POS_N-1:0]   act_ff, act_in, nx_ff, nx_in;
   logic [7:0]                  byte_ff, byte_in, lo_ff, lo_in;
   logic                        last_ff, last_in;
   logic [2:0]                  cls_ff, cls_in;
   logic                        neg_ff, neg_in, hit_ff, hit_in;
   logic                        lcar_ff, lcar_in, tcar_ff, tcar_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        matched_ff, matched_in, ovf_ff, ovf_in;

   logic                        rsp_free;
   logic [7:0]                  b;
   logic                        live, is_star, star_set, t_k, t_end, ok;
   logic                        hit_v, do_item, do_close;

   assign rsp_free             = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_matched          = matched_ff;
   assign rsp_pattern_overflow = ovf_ff;
   assign pos_p1               = pos_ff + 1'b1;
   assign b                    = rdata_ff;
   assign raddr = (state_ff == gpm_pkg::ST_IDLE) ? '0 : pos_p1[gpm_pkg::IDX_W-1:0];

   // Pattern store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pat_mem_ff[len_ff[gpm_pkg::IDX_W-1:0]] <= cmd.data;
      end
      rdata_ff <= pat_mem_ff[raddr];
   end

   // Command execution and the position pass.
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      act_in       = act_ff;
      nx_in        = nx_ff;
      pos_in       = pos_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      cls_in       = cls_ff;
      neg_in       = neg_ff;
      hit_in       = hit_ff;
      lo_in        = lo_ff;
      lcar_in      = lcar_ff;
      tcar_in      = tcar_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      matched_in   = matched_ff;
      ovf_in       = ovf_ff;
      mem_we       = 1'b0;
      cmd_ready    = 1'b0;
      live         = 1'b0;
      is_star      = 1'b0;
      star_set     = 1'b0;
      t_k          = 1'b0;
      t_end        = 1'b0;
      ok           = 1'b0;
      hit_v        = hit_ff;
      do_item      = 1'b0;
      do_close     = 1'b0;

      case (state_ff)
         gpm_pkg::ST_IDLE: begin
            cmd_ready = rsp_free;
            if (cmd_valid && rsp_free) begin
               case (cmd.kind)
                  gpm_pkg::OP_CLEAR: begin
                     len_in = '0;
                     act_in = gpm_pkg::ACT_START;
                  end
                  gpm_pkg::OP_APPEND: begin
                     act_in = gpm_pkg::ACT_START;
                     if (len_ff < gpm_pkg::LEN_MAX) begin
                        mem_we = 1'b1;
                        len_in = len_ff + 1'b1;
                     end else begin
                        rsp_valid_in = 1'b1;
                        matched_in   = 1'b0;
                        ovf_in       = 1'b1;
                     end
                  end
                  gpm_pkg::OP_NAME: begin
                     byte_in  = cmd.data;
                     last_in  = cmd.last;
                     pos_in   = '0;
                     nx_in    = '0;
                     cls_in   = gpm_pkg::CLS_NONE;
                     lcar_in  = 1'b0;
                     tcar_in  = 1'b0;
                     state_in = gpm_pkg::ST_PASS;
                  end
                  default: begin
                  end
               endcase
            end
         end

         gpm_pkg::ST_PASS: begin
            if (pos_ff != len_ff) begin
               // Live bit with the star closure chained in from below.
               live     = act_ff[pos_ff] | lcar_ff;
               is_star  = (b == gpm_pkg::CH_STAR);
               lcar_in  = live & is_star;
               star_set = live & is_star & (cls_ff == gpm_pkg::CLS_NONE);
               t_k      = nx_ff[pos_ff] | star_set | tcar_ff;
               tcar_in  = t_k & is_star;
               pos_in   = pos_p1;

               case (cls_ff)
                  gpm_pkg::CLS_NONE: begin
                     if (live) begin
                        case (b)
                           gpm_pkg::CH_STAR:  nx_in[pos_ff] = 1'b1;
                           gpm_pkg::CH_QUEST: nx_in[pos_p1] = 1'b1;
                           gpm_pkg::CH_OPEN: begin
                              cls_in = gpm_pkg::CLS_FIRST;
                              neg_in = 1'b0;
                              hit_in = 1'b0;
                           end
                           default: begin
                              if (b == byte_ff) begin
                                 nx_in[pos_p1] = 1'b1;
                              end
                           end
                        endcase
                     end
                  end
                  gpm_pkg::CLS_FIRST: begin
                     if (b == gpm_pkg::CH_BANG || b == gpm_pkg::CH_CARET) begin
                        neg_in = 1'b1;
                        cls_in = gpm_pkg::CLS_ITEM;
                     end else begin
                        do_item = 1'b1;
                     end
                  end
                  gpm_pkg::CLS_ITEM: do_item = 1'b1;
                  gpm_pkg::CLS_DASH: begin
                     if (b == gpm_pkg::CH_DASH) begin
                        cls_in = gpm_pkg::CLS_HI;
                     end else begin
                        // The held byte stood for itself.
                        hit_v   = hit_ff | (byte_ff == lo_ff);
                        do_item = 1'b1;
                     end
                  end
                  gpm_pkg::CLS_HI: begin
                     if (b != gpm_pkg::CH_CLOSE) begin
                        hit_v  = hit_ff | ((byte_ff >= lo_ff) && (byte_ff <= b));
                        cls_in = gpm_pkg::CLS_ITEM;
                     end else begin
                        hit_v    = hit_ff | (byte_ff == lo_ff) | (byte_ff == gpm_pkg::CH_DASH);
                        do_close = 1'b1;
                     end
                  end
                  default: cls_in = gpm_pkg::CLS_NONE;
               endcase

               // A class member: either the closing bracket or a new low byte.
               if (do_item) begin
                  if (b == gpm_pkg::CH_CLOSE) begin
                     do_close = 1'b1;
                  end else begin
                     lo_in  = b;
                     cls_in = gpm_pkg::CLS_DASH;
                  end
               end
               if (cls_ff != gpm_pkg::CLS_NONE) begin
                  hit_in = hit_v;
               end
               if (do_close) begin
                  cls_in = gpm_pkg::CLS_NONE;
                  if (hit_v != neg_ff) begin
                     nx_in[pos_p1] = 1'b1;
                  end
               end
            end else begin
               // End of pattern: an open class runs to the end.
               case (cls_ff)
                  gpm_pkg::CLS_DASH: hit_v = hit_ff | (byte_ff == lo_ff);
                  gpm_pkg::CLS_HI:
                     hit_v = hit_ff | (byte_ff == lo_ff) | (byte_ff == gpm_pkg::CH_DASH);
                  default: hit_v = hit_ff;
               endcase
               ok    = (cls_ff != gpm_pkg::CLS_NONE) && (hit_v != neg_ff);
               t_end = nx_ff[len_ff] | ok | tcar_ff;
               if (!last_ff || rsp_free) begin
                  state_in = gpm_pkg::ST_IDLE;
                  cls_in   = gpm_pkg::CLS_NONE;
                  if (last_ff) begin
                     act_in       = gpm_pkg::ACT_START;
                     rsp_valid_in = 1'b1;
                     matched_in   = filter_enabled ? t_end : 1'b1;
                     ovf_in       = 1'b0;
                  end else begin
                     act_in         = nx_ff;
                     act_in[len_ff] = nx_ff[len_ff] | ok;
                  end
               end
            end
         end

         default: state_in = gpm_pkg::ST_IDLE;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gpm_pkg::ST_IDLE;
         len_ff       <= '0;
         act_ff       <= gpm_pkg::ACT_START;
         cls_ff       <= gpm_pkg::CLS_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         act_ff       <= act_in;
         cls_ff       <= cls_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers of the pass and the result payload.
   always_ff @(posedge clock) begin
      nx_ff      <= nx_in;
      pos_ff     <= pos_in;
      byte_ff    <= byte_in;
      last_ff    <= last_in;
      neg_ff     <= neg_in;
      hit_ff     <= hit_in;
      lo_ff      <= lo_in;
      lcar_ff    <= lcar_in;
      tcar_ff    <= tcar_in;
      matched_ff <= matched_in;
      ovf_ff     <= ovf_in;
   end

endmodule

// ===== rtl/core/glob_pattern_matcher_core.sv =====
// Top level of the glob pattern matcher: control register and the two parts.
//
// Patterns are loaded one byte per request into a 32-byte store, and names
// then stream in one byte per request; on a name's last byte one response
// carries the verdict (always a match while filter_enabled is 0). A pattern
// byte that finds the store full is dropped and answered with
// pattern_overflow. Clear and append requests are done by the back unit in
// its idle state. For a name byte the back unit reads the pattern store one
// position per cycle, in one ascending pass that applies the star closure,
// single-byte steps and bracket classes. A two-entry request queue lets the
// front keep accepting while that pass runs; the response register holds a
// verdict until taken, and the back unit takes no command while it is full.
module glob_pattern_matcher_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_op,
   input  logic [7:0] req_data_byte,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_matched,
   output logic       rsp_pattern_overflow,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_filter_enabled
);

   gpm_pkg::cmd_type cmd;
   logic             cmd_valid, cmd_ready;
   logic             filter_ff;

   // Filter enable register; a write is always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_ff <= 1'b0;
      end else if (csr_valid) begin
         filter_ff <= csr_filter_enabled;
      end
   end

   gpm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_data_byte (req_data_byte),
      .req_is_last   (req_is_last),
      .cmd_valid     (cmd_valid),
      .cmd_ready     (cmd_ready),
      .cmd           (cmd)
   );

   gpm_back u_back (
      .clock                (clock),
      .reset                (reset),
      .cmd_valid            (cmd_valid),
      .cmd_ready            (cmd_ready),
      .cmd                  (cmd),
      .filter_enabled       (filter_ff),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_matched          (rsp_matched),
      .rsp_pattern_overflow (rsp_pattern_overflow)
   );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the glob pattern matcher core.
`timescale 1ns / 1ps

module tb_top;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_op;
   logic [7:0] req_data_byte;
   logic       req_is_last;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_matched;
   logic       rsp_pattern_overflow;
   logic       csr_valid;
   logic       csr_ready;
   logic       csr_filter_enabled;

   typedef struct packed {
      logic matched;
      logic overflow;
   } verdict_type;

   // Shadow state of the matcher.
   logic [7:0]                pat_mem [gpm_pkg::PATTERN_MAX];
   int                        pat_len;
   logic [gpm_pkg::POS_N-1:0] live_set;
   logic                      filter_on;

   verdict_type verdict_queue[$];
   int          fail_count;
   int          verdicts_seen;
   bit          hold_off;
   int          stall_pct;
   int          gap_max;

   glob_pattern_matcher_core u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_op               (req_op),
      .req_data_byte        (req_data_byte),
      .req_is_last          (req_is_last),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_matched          (rsp_matched),
      .rsp_pattern_overflow (rsp_pattern_overflow),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_filter_enabled   (csr_filter_enabled)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [7:0] pat_byte(int i);
      return (i < pat_len) ? pat_mem[i] : 8'd0;
   endfunction

   // Add the position after each live star, ascending so runs of stars chain.
   function automatic logic [gpm_pkg::POS_N-1:0] close_stars(logic [gpm_pkg::POS_N-1:0] s);
      for (int i = 0; i < pat_len; i++) begin
         if (s[i] && pat_byte(i) == gpm_pkg::CH_STAR) s[i+1] = 1'b1;
      end
      return s;
   endfunction

   // Bracket class at position i: returns the position after it and the hit.
   function automatic int class_match(int i, logic [7:0] c, output bit ok);
      int q;
      bit neg;
      bit hit;
      q = i + 1;
      neg = 0;
      hit = 0;
      if (q < pat_len && (pat_byte(q) == gpm_pkg::CH_BANG ||
                          pat_byte(q) == gpm_pkg::CH_CARET)) begin
         neg = 1;
         q++;
      end
      while (q < pat_len && pat_byte(q) != gpm_pkg::CH_CLOSE) begin
         if (q + 2 < pat_len && pat_byte(q + 1) == gpm_pkg::CH_DASH &&
             pat_byte(q + 2) != gpm_pkg::CH_CLOSE) begin
            if (c >= pat_byte(q) && c <= pat_byte(q + 2)) hit = 1;
            q += 3;
         end else begin
            if (c == pat_byte(q)) hit = 1;
            q++;
         end
      end
      if (q < pat_len) q++;
      ok = (hit != neg);
      return q;
   endfunction

   function automatic logic [gpm_pkg::POS_N-1:0] step_set(logic [gpm_pkg::POS_N-1:0] s,
                                                          logic [7:0] c);
      logic [gpm_pkg::POS_N-1:0] nxt;
      logic [7:0]                pc;
      bit                        ok;
      int                        q;
      nxt = '0;
      for (int i = 0; i < pat_len; i++) begin
         if (s[i]) begin
            pc = pat_byte(i);
            if (pc == gpm_pkg::CH_STAR) begin
               nxt[i] = 1'b1;
            end else if (pc == gpm_pkg::CH_QUEST) begin
               nxt[i+1] = 1'b1;
            end else if (pc == gpm_pkg::CH_OPEN) begin
               q = class_match(i, c, ok);
               if (ok) nxt[q] = 1'b1;
            end else if (pc == c) begin
               nxt[i+1] = 1'b1;
            end
         end
      end
      return nxt;
   endfunction

   // Update the shadow state for one accepted request and queue any verdict.
   task automatic predict_request(logic [1:0] op, logic [7:0] b, logic last);
      logic [gpm_pkg::POS_N-1:0] s;
      verdict_type v;
      case (op)
         gpm_pkg::OP_CLEAR: begin
            pat_len = 0;
            live_set = gpm_pkg::ACT_START;
         end
         gpm_pkg::OP_APPEND: begin
            live_set = gpm_pkg::ACT_START;
            if (pat_len < gpm_pkg::PATTERN_MAX) begin
               pat_mem[pat_len] = b;
               pat_len++;
            end else begin
               v.matched = 1'b0;
               v.overflow = 1'b1;
               verdict_queue.push_back(v);
            end
         end
         gpm_pkg::OP_NAME: begin
            s = close_stars(step_set(close_stars(live_set), b));
            if (!last) begin
               live_set = s;
            end else begin
               v.matched = filter_on ? s[pat_len] : 1'b1;
               v.overflow = 1'b0;
               verdict_queue.push_back(v);
               live_set = gpm_pkg::ACT_START;
            end
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic int random_gap();
      if (gap_max == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return ($urandom_range(0, 2) == 0) ? $urandom_range(1, gap_max) : 0;
   endfunction

   // Send one request, then predict it once it has been accepted. Valid stays
   // high after acceptance so back-to-back requests need no extra edge; idle
   // gaps and the drain task drop it.
   task automatic send_request(logic [1:0] op, logic [7:0] b, logic last);
      int gap;
      gap = random_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_data_byte <= b;
      req_is_last <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_request(op, b, last);
   endtask

   // Stop offering requests and let every request in flight finish.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (verdict_queue.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_filter(logic en);
      wait_drained();
      csr_valid <= 1'b1;
      csr_filter_enabled <= en;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      filter_on = en;
      csr_valid <= 1'b0;
   endtask

   task automatic load_pattern(string p);
      send_request(gpm_pkg::OP_CLEAR, 8'($urandom), 1'($urandom));
      for (int i = 0; i < p.len(); i++)
         send_request(gpm_pkg::OP_APPEND, p[i], 1'($urandom));
   endtask

   task automatic send_name(string n);
      for (int i = 0; i < n.len(); i++)
         send_request(gpm_pkg::OP_NAME, n[i], i == n.len() - 1);
   endtask

   // Result checker and receiver stall control.
   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            verdicts_seen++;
            if (verdict_queue.size() == 0) begin
               report_mismatch("unexpected response", 1, 0);
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_matched !== want.matched)
                  report_mismatch("matched", rsp_matched, want.matched);
               if (rsp_pattern_overflow !== want.overflow)
                  report_mismatch("pattern_overflow", rsp_pattern_overflow, want.overflow);
            end
         end
         rsp_ready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic test_directed();
      write_filter(1'b1);
      load_pattern("a*b?c");
      send_name("axyzbqc");
      send_name("abc");
      send_name("a/b/bxc");
      load_pattern("[!a-c]x[^]]");
      send_name("dxz");
      send_name("axz");
      load_pattern("[]x");
      send_name("]x");
      load_pattern("[!]");
      send_name("q");
      load_pattern("[a-]z");
      send_name("-z");
      load_pattern("[x");
      send_name("x");
      send_request(OP_UNUSED, 8'hFF, 1'b1);
      load_pattern("");
      send_request(gpm_pkg::OP_NAME, 8'h00, 1'b1);
      send_request(gpm_pkg::OP_NAME, 8'hFF, 1'b1);
      write_filter(1'b0);
      send_name("zz");
   endtask

   task automatic test_overflow();
      write_filter(1'b1);
      send_request(gpm_pkg::OP_CLEAR, 8'h00, 1'b0);
      for (int i = 0; i < gpm_pkg::PATTERN_MAX + 2; i++)
         send_request(gpm_pkg::OP_APPEND, 8'h2A, 1'b0);
      send_name("any");
   endtask

   function automatic string random_text(int n, bit is_pat);
      string s;
      byte   alpha[] = '{"a", "b", "c", "*", "?", "[", "]", "!", "^", "-", "/"};
      s = "";
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0)
            s = {s, string'(byte'($urandom_range(0, 255)))};
         else if (is_pat)
            s = {s, string'(alpha[$urandom_range(0, alpha.size() - 1)])};
         else
            s = {s, string'(alpha[$urandom_range(0, 2)])};
      end
      return s;
   endfunction

   task automatic send_name_bytes(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_request(gpm_pkg::OP_NAME, 8'($urandom), i == n - 1);
         else
            send_request(gpm_pkg::OP_NAME, 8'("a" + $urandom_range(0, 2)), i == n - 1);
      end
   endtask

   task automatic test_random(int budget, logic en);
      int sent;
      int n;
      string p;
      write_filter(en);
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(0, 15) == 0) begin
            send_request(2'($urandom), 8'($urandom), 1'($urandom));
            sent++;
         end else if ($urandom_range(0, 3) == 0) begin
            p = random_text($urandom_range(0, 8), 1'b1);
            load_pattern(p);
            sent += p.len() + 1;
         end else begin
            n = $urandom_range(1, 6);
            send_name_bytes(n);
            sent += n;
         end
      end
   endtask

   // Hold the receiver off while requests keep flowing so the block backs up.
   task automatic test_backpressure();
      int cnt;
      write_filter(1'b1);
      load_pattern("*a");
      hold_off = 1'b1;
      fork
         begin
            cnt = 0;
            while (cnt < 400) begin
               @(posedge clock);
               cnt++;
            end
            hold_off = 1'b0;
         end
         for (int i = 0; i < 8; i++) send_name("ba");
      join
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = gpm_pkg::OP_CLEAR;
      req_data_byte = 8'd0;
      req_is_last = 1'b0;
      csr_valid = 1'b0;
      csr_filter_enabled = 1'b0;
      fail_count = 0;
      verdicts_seen = 0;
      hold_off = 1'b0;
      stall_pct = 30;
      gap_max = 3;
      pat_len = 0;
      live_set = gpm_pkg::ACT_START;
      filter_on = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_overflow();
      test_backpressure();
      test_random(250, 1'b1);
      stall_pct = 0;
      gap_max = 0;
      test_random(80, 1'b1);
      stall_pct = 60;
      gap_max = 6;
      test_random(100, 1'b0);
      stall_pct = 20;
      gap_max = 2;
      test_random(120, 1'b1);
      wait_drained();
      if (fail_count == 0 && verdict_queue.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/gpm_pkg.sv
rtl/core/gpm_front.sv
rtl/core/gpm_back.sv
rtl/core/glob_pattern_matcher_core.sv
test/tb_top.sv
